FILE: src/mp3d_pkg.sv
// Shared types and constants for the 3D max pool with argmax block.
`default_nettype none
package mp3d_pkg;
  localparam int unsigned VOL_H  = 16;
  localparam int unsigned VOL_W  = 16;
  localparam int unsigned VOL_D  = 16;
  localparam int unsigned POOL_H = 2;
  localparam int unsigned POOL_W = 2;
  localparam int unsigned POOL_D = 2;

  localparam int unsigned AH = $clog2(VOL_H) > 0 ? $clog2(VOL_H) : 1;
  localparam int unsigned AW = $clog2(VOL_W) > 0 ? $clog2(VOL_W) : 1;
  localparam int unsigned AD = $clog2(VOL_D) > 0 ? $clog2(VOL_D) : 1;
  localparam int unsigned ADDR_W = AH + AW + AD;
  localparam int unsigned DEPTH = VOL_H * VOL_W * VOL_D;
  localparam int unsigned PH_W = $clog2(POOL_H + 1);
  localparam int unsigned PW_W = $clog2(POOL_W + 1);
  localparam int unsigned PD_W = $clog2(POOL_D + 1);
  // signed window coordinate: covers 31*31 down to -15
  localparam int unsigned CW = 11;
  localparam int unsigned IDX_W = 29;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_W    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_D    = 3'd5;

  typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_e;

  // classified command passed from front to back
  typedef struct packed {
    op_e                      op;
    logic signed [15:0]       value;
    logic [ADDR_W-1:0]        addr;
    logic                     in_vol;
    logic signed [CW-1:0]     oh;
    logic signed [CW-1:0]     ow;
    logic signed [CW-1:0]     od;
    logic [15:0]              vol;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic [IDX_W-1:0]   max_index;
    logic               window_empty;
  } res_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_DONE} bk_state_e;
endpackage
`default_nettype wire

FILE: src/mp3d_front.sv
// Front end: accepts requests, computes window origins and load addresses.
`default_nettype none
module mp3d_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire  [63:0]         data_i,
  input  wire  [4:0]          stride_h_i,
  input  wire  [4:0]          stride_w_i,
  input  wire  [4:0]          stride_d_i,
  input  wire  [3:0]          pad_h_i,
  input  wire  [3:0]          pad_w_i,
  input  wire  [3:0]          pad_d_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output mp3d_pkg::cmd_t      cmd_o
);
  import mp3d_pkg::*;

  logic valid_q;
  cmd_t cmd_q, cmd_d;
  logic [3:0] sh, sw, sd;
  logic [4:0] qh, qw, qd;

  assign sh = data_i[20:17];
  assign sw = data_i[24:21];
  assign sd = data_i[28:25];
  assign qh = data_i[33:29];
  assign qw = data_i[38:34];
  assign qd = data_i[43:39];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

  always_comb begin
    cmd_d.op     = op_e'(data_i[0]);
    cmd_d.value  = data_i[16:1];
    cmd_d.in_vol = (32'(sh) < VOL_H) && (32'(sw) < VOL_W) && (32'(sd) < VOL_D);
    cmd_d.addr   = {sd[AD-1:0], sw[AW-1:0], sh[AH-1:0]};
    cmd_d.oh     = CW'($signed({1'b0, CW'(qh * stride_h_i)}) - $signed({1'b0, CW'(pad_h_i)}));
    cmd_d.ow     = CW'($signed({1'b0, CW'(qw * stride_w_i)}) - $signed({1'b0, CW'(pad_w_i)}));
    cmd_d.od     = CW'($signed({1'b0, CW'(qd * stride_d_i)}) - $signed({1'b0, CW'(pad_d_i)}));
    cmd_d.vol    = data_i[59:44];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cmd_q <= cmd_d;
    end
  end
endmodule
`default_nettype wire

FILE: src/mp3d_back.sv
// Back end: volume memory, window scan and result register.
`default_nettype none
module mp3d_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  mp3d_pkg::cmd_t      cmd_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output mp3d_pkg::res_t      res_o
);
  import mp3d_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q;

  bk_state_e state_q, state_d;
  cmd_t cmd_q;
  logic [PH_W-1:0] r_q, r_d;
  logic [PW_W-1:0] s_q, s_d;
  logic [PD_W-1:0] t_q, t_d;
  logic rd_v_q, rd_v_d;
  logic [ADDR_W-1:0] pos_q, rd_addr;
  logic found_q, found_d;
  logic signed [15:0] best_q, best_d;
  logic [ADDR_W-1:0] bpos_q, bpos_d;
  logic signed [CW:0] xh, xw, xd;
  logic in_win;
  logic out_v_q;
  res_t res_q;
  logic take, load_now;

  assign xh = {cmd_q.oh[CW-1], cmd_q.oh} + (CW+1)'(r_q);
  assign xw = {cmd_q.ow[CW-1], cmd_q.ow} + (CW+1)'(s_q);
  assign xd = {cmd_q.od[CW-1], cmd_q.od} + (CW+1)'(t_q);
  assign in_win = xh >= 0 && xh < (CW+1)'(VOL_H) && xw >= 0 && xw < (CW+1)'(VOL_W)
               && xd >= 0 && xd < (CW+1)'(VOL_D);
  assign rd_addr = {xd[AD-1:0], xw[AW-1:0], xh[AH-1:0]};

  assign ready_o  = state_q == ST_IDLE;
  assign take     = ready_o && valid_i;
  assign load_now = take && cmd_i.op == OP_LOAD && cmd_i.in_vol;

  always_ff @(posedge clk_i) begin
    if (load_now) begin
      mem[cmd_i.addr] <= cmd_i.value;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    r_d = r_q; s_d = s_q; t_d = t_q;
    rd_v_d  = 1'b0;
    found_d = found_q; best_d = best_q; bpos_d = bpos_q;
    if (rd_v_q && (!found_q || $signed(rd_q) >= best_q)) begin
      found_d = 1'b1;
      best_d  = rd_q;
      bpos_d  = pos_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (take && cmd_i.op == OP_QUERY) begin
          state_d = ST_SCAN;
          r_d = '0; s_d = '0; t_d = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        rd_v_d = in_win;
        if (32'(r_q) + 1 < POOL_H) begin
          r_d = r_q + 1'b1;
        end else begin
          r_d = '0;
          if (32'(s_q) + 1 < POOL_W) begin
            s_d = s_q + 1'b1;
          end else begin
            s_d = '0;
            if (32'(t_q) + 1 < POOL_D) t_d = t_q + 1'b1;
            else state_d = ST_LAST;
          end
        end
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: if (!out_v_q || ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_v_d;
      if (state_q == ST_DONE && (!out_v_q || ready_i)) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; s_q <= s_d; t_q <= t_d;
    found_q <= found_d; best_q <= best_d; bpos_q <= bpos_d;
    pos_q <= rd_addr;
    if (take) cmd_q <= cmd_i;
    if (state_q == ST_DONE && (!out_v_q || ready_i)) begin
      if (found_q) begin
        res_q.max_value    <= best_q;
        res_q.max_index    <= IDX_W'(bpos_q) + IDX_W'(cmd_q.vol) * IDX_W'(DEPTH) + 1'b1;
        res_q.window_empty <= 1'b0;
      end else begin
        res_q.max_value    <= 16'sh8000;
        res_q.max_index    <= '0;
        res_q.window_empty <= 1'b1;
      end
    end
  end

  assign valid_o = out_v_q;
  assign res_o   = res_q;
endmodule
`default_nettype wire

FILE: src/max_pool_3d_with_argmax_core.sv
// Top level of the 3D max pool with argmax block.
// Input stream s_axis: each request either loads one sample into the
// on-chip volume (operation 0) or queries one pooled output (operation 1).
// A query returns one result on m_axis; a load returns nothing.
// The front stage registers and classifies a request and computes the
// window origin; a one-entry queue feeds the back stage, which owns the
// volume memory. A load is written while the back stage stays idle. A
// query reads the POOL_H*POOL_W*POOL_D window entries one per cycle from
// the single read port, then passes through ST_LAST and ST_DONE before
// the back stage takes another request.
// Results wait in an output register; the back stage stalls when that
// register is full and the receiver holds tready low, and the front
// keeps one more request queued meanwhile.
// Reset clears control state and configuration (strides 1, pads 0);
// the volume memory is not cleared and must be loaded before use.
// Configuration writes via cfg_we_i must come only while no request is in flight.
`default_nettype none
module max_pool_3d_with_argmax_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, sample_value, sample_h, sample_w, sample_d, out_h, out_w,
  // out_d, volume_number, zero pad
  input  wire  [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // max_value, max_index, window_empty, zero pad
  output logic [47:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [4:0]  cfg_data_i
);
  import mp3d_pkg::*;

  logic [4:0] stride_h_q, stride_w_q, stride_d_q;
  logic [3:0] pad_h_q, pad_w_q, pad_d_q;
  logic fv, br;
  cmd_t cmd;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_h_q <= 5'd1; stride_w_q <= 5'd1; stride_d_q <= 5'd1;
      pad_h_q <= '0; pad_w_q <= '0; pad_d_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STRIDE_H: stride_h_q <= cfg_data_i;
        REG_STRIDE_W: stride_w_q <= cfg_data_i;
        REG_STRIDE_D: stride_d_q <= cfg_data_i;
        REG_PAD_H:    pad_h_q <= cfg_data_i[3:0];
        REG_PAD_W:    pad_w_q <= cfg_data_i[3:0];
        REG_PAD_D:    pad_d_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  mp3d_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready), .data_i(s_axis_tdata),
    .stride_h_i(stride_h_q), .stride_w_i(stride_w_q), .stride_d_i(stride_d_q),
    .pad_h_i(pad_h_q), .pad_w_i(pad_w_q), .pad_d_i(pad_d_q),
    .valid_o(fv), .ready_i(br), .cmd_o(cmd)
  );

  mp3d_back u_back (
    .clk_i, .rst_ni,
    .valid_i(fv), .ready_o(br), .cmd_i(cmd),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {2'b00, res.window_empty, res.max_index, res.max_value};
endmodule
`default_nettype wire

FILE: tb/tb_max_pool_3d_with_argmax_core.sv
// Testbench for the 3D max pool with argmax core: streamed loads and queries checked against a local pooling model.
`timescale 1ns / 100ps
module tb_max_pool_3d_with_argmax_core;
  import mp3d_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // operation, sample_value, sample_h, sample_w, sample_d, out_h, out_w, out_d, volume_number
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // max_value, max_index, window_empty
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [4:0]  cfg_data_i = '0;

  max_pool_3d_with_argmax_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0]        pending_req[$];
  res_t               pooled_q[$];
  logic signed [15:0] vol_copy [DEPTH];
  bit                 planned [DEPTH];
  int unsigned        stride_hc = 1, stride_wc = 1, stride_dc = 1;
  int unsigned        pad_hc = 0, pad_wc = 0, pad_dc = 0;
  int                 send_idle_pct = 0, recv_idle_pct = 0;
  int                 errors = 0, n_loads = 0, n_queries = 0, n_empty = 0, n_results = 0;
  int                 hold_reqs = 0, hold_seen = 0, hold_cnt = 0;
  int unsigned        cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] pack_req(op_e op, logic [15:0] v, logic [3:0] h,
      logic [3:0] w, logic [3:0] d, logic [4:0] oh, logic [4:0] ow, logic [4:0] od,
      logic [15:0] vn);
    return {4'b0, vn, od, ow, oh, d, w, h, v, op};
  endfunction

  // true when every in-volume position of the window has a load queued before it
  function automatic bit window_ok(logic [4:0] oh, logic [4:0] ow, logic [4:0] od);
    int bh, bw, bd, xh, xw, xd;
    int unsigned pos;
    bit ok;
    bh = int'(oh) * int'(stride_hc) - int'(pad_hc);
    bw = int'(ow) * int'(stride_wc) - int'(pad_wc);
    bd = int'(od) * int'(stride_dc) - int'(pad_dc);
    ok = 1;
    for (int t = 0; t < POOL_D; t++) begin
      for (int s = 0; s < POOL_W; s++) begin
        for (int q = 0; q < POOL_H; q++) begin
          xd = bd + t;
          xw = bw + s;
          xh = bh + q;
          if (xd >= 0 && xd < VOL_D && xw >= 0 && xw < VOL_W && xh >= 0 && xh < VOL_H) begin
            pos = xh + xw * VOL_H + xd * VOL_H * VOL_W;
            if (!planned[pos]) ok = 0;
          end
        end
      end
    end
    return ok;
  endfunction

  function automatic void push_load(logic [15:0] v, logic [3:0] h, logic [3:0] w,
      logic [3:0] d);
    pending_req.push_back(pack_req(OP_LOAD, v, h, w, d, 5'd0, 5'd0, 5'd0, 16'd0));
    planned[{d, w, h}] = 1'b1;
  endfunction

  function automatic void push_query(logic [4:0] oh, logic [4:0] ow, logic [4:0] od,
      logic [15:0] vn);
    if (window_ok(oh, ow, od))
      pending_req.push_back(pack_req(OP_QUERY, 16'd0, 4'd0, 4'd0, 4'd0, oh, ow, od, vn));
  endfunction

  function automatic res_t pool_window(logic [4:0] oh, logic [4:0] ow, logic [4:0] od,
      logic [15:0] vn);
    int bh, bw, bd, xh, xw, xd;
    int best;
    int unsigned pos, best_pos;
    bit found;
    logic [63:0] idx;
    res_t r;
    bh = int'(oh) * int'(stride_hc) - int'(pad_hc);
    bw = int'(ow) * int'(stride_wc) - int'(pad_wc);
    bd = int'(od) * int'(stride_dc) - int'(pad_dc);
    found = 0;
    best = -32768;
    best_pos = 0;
    for (int t = 0; t < POOL_D; t++) begin
      for (int s = 0; s < POOL_W; s++) begin
        for (int q = 0; q < POOL_H; q++) begin
          xd = bd + t;
          xw = bw + s;
          xh = bh + q;
          if (xd >= 0 && xd < VOL_D && xw >= 0 && xw < VOL_W && xh >= 0 && xh < VOL_H) begin
            pos = xh + xw * VOL_H + xd * VOL_H * VOL_W;
            if (!found || int'(vol_copy[pos]) >= best) begin
              found = 1;
              best = vol_copy[pos];
              best_pos = pos;
            end
          end
        end
      end
    end
    if (found) begin
      idx = 64'(best_pos) + 64'(vn) * 64'(DEPTH) + 64'd1;
      r.max_value = 16'(best);
      r.max_index = idx[IDX_W-1:0];
      r.window_empty = 1'b0;
    end else begin
      r.max_value = 16'sh8000;
      r.max_index = '0;
      r.window_empty = 1'b1;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (op_e'(s_axis_tdata[0]) == OP_LOAD) begin
          vol_copy[{s_axis_tdata[28:25], s_axis_tdata[24:21], s_axis_tdata[20:17]}] =
            s_axis_tdata[16:1];
          n_loads++;
        end else begin
          pooled_q.push_back(pool_window(s_axis_tdata[33:29], s_axis_tdata[38:34],
                                         s_axis_tdata[43:39], s_axis_tdata[59:44]));
          n_queries++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= pending_req.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.max_value = m_axis_tdata[15:0];
        got.max_index = m_axis_tdata[44:16];
        got.window_empty = m_axis_tdata[45];
        n_results++;
        if (pooled_q.size() == 0) begin
          report("unexpected result", 64'(got), 64'd0);
        end else begin
          want = pooled_q.pop_front();
          if (got.max_value !== want.max_value)
            report("max_value", 64'(got.max_value), 64'(want.max_value));
          if (got.max_index !== want.max_index)
            report("max_index", 64'(got.max_index), 64'(want.max_index));
          if (got.window_empty !== want.window_empty)
            report("window_empty", 64'(got.window_empty), 64'(want.window_empty));
          if (want.window_empty) n_empty++;
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain(input int extra);
    while (pending_req.size() > 0 || s_axis_tvalid || pooled_q.size() > 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_STRIDE_H: stride_hc = val;
      REG_STRIDE_W: stride_wc = val;
      REG_STRIDE_D: stride_dc = val;
      REG_PAD_H:    pad_hc = val[3:0];
      REG_PAD_W:    pad_wc = val[3:0];
      REG_PAD_D:    pad_dc = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_pool(input int sh, sw, sd, ph, pw, pd);
    write_cfg(REG_STRIDE_H, 5'(sh));
    write_cfg(REG_STRIDE_W, 5'(sw));
    write_cfg(REG_STRIDE_D, 5'(sd));
    write_cfg(REG_PAD_H, 5'(ph));
    write_cfg(REG_PAD_W, 5'(pw));
    write_cfg(REG_PAD_D, 5'(pd));
  endtask

  // random load anywhere, or a query whose window only touches loaded entries
  function automatic void push_rand();
    logic [63:0] r;
    logic [4:0] qh, qw, qd;
    bit ok;
    r = {$urandom, $urandom};
    r[63:60] = '0;
    ok = 0;
    qh = '0; qw = '0; qd = '0;
    if ($urandom_range(99) < 70) begin
      for (int n = 0; n < 20 && !ok; n++) begin
        if ($urandom_range(3) != 0) begin
          // keep most windows near the volume so they hit real samples
          qh = 5'($urandom_range(17));
          qw = 5'($urandom_range(17));
          qd = 5'($urandom_range(17));
        end else begin
          qh = 5'($urandom);
          qw = 5'($urandom);
          qd = 5'($urandom);
        end
        ok = window_ok(qh, qw, qd);
      end
    end
    if (ok) begin
      r[0] = OP_QUERY;
      r[33:29] = qh;
      r[38:34] = qw;
      r[43:39] = qd;
    end else begin
      r[0] = OP_LOAD;
      planned[{r[28:25], r[24:21], r[20:17]}] = 1'b1;
    end
    pending_req.push_back(r);
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the low corner of the volume; queries only touch loaded entries
    for (int a = 0; a < 512; a++)
      push_load(16'($urandom), 4'(a & 7), 4'((a >> 3) & 7), 4'(a >> 6));
    // extremes and ties
    push_load(16'h7fff, 4'd0, 4'd0, 4'd0);
    push_load(16'h8000, 4'd1, 4'd0, 4'd0);
    push_load(16'h7fff, 4'd0, 4'd1, 4'd1);
    for (int k = 0; k < 8; k++)
      push_load(16'h8000, 4'(14 + k[0]), 4'(14 + k[1]), 4'(14 + k[2]));
    for (int k = 0; k < 4; k++)
      push_load(16'h0123, 4'(4 + k[0]), 4'(4 + k[1]), 4'd4);
    push_query(5'd0, 5'd0, 5'd0, 16'd0);
    push_query(5'd14, 5'd14, 5'd14, 16'hffff);
    push_query(5'd15, 5'd15, 5'd15, 16'd1);
    push_query(5'd31, 5'd31, 5'd31, 16'd0);
    push_query(5'd16, 5'd0, 5'd0, 16'd7);
    push_query(5'd2, 5'd2, 5'd2, 16'h8000);
    drain(30);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_pool(1, 1, 1, 0, 0, 0);
        1: set_pool(2, 2, 2, 1, 1, 1);
        2: set_pool(16, 16, 16, 15, 15, 15);
        3: set_pool(0, 0, 0, 0, 0, 0);
        4: set_pool(31, 31, 31, 0, 0, 0);
        5: set_pool(0, 3, 31, 15, 1, 0);
        6: set_pool(1, 1, 1, 1, 1, 1);
        default: set_pool($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                          $urandom_range(2), $urandom_range(2), $urandom_range(2));
      endcase
      send_idle_pct = (ph < 3) ? 11 : (ph < 6) ? 54 : 0;
      recv_idle_pct = (ph < 3) ? 54 : (ph < 6) ? 11 : 0;
      for (int k = 0; k < 180; k++) push_rand();
      if (ph == 1 || ph == 6) begin
        repeat (20) @(posedge clk_i);
        hold_reqs++;
      end
      // ties inside one window under the unit stride settings
      if (ph == 6)
        for (int k = 0; k < 8; k++)
          push_load(16'h4000, 4'(8 + k[0]), 4'(8 + k[1]), 4'(8 + k[2]));
      push_query(5'd9, 5'd9, 5'd9, 16'd3);
      drain(30);
    end

    $display("covered %0d loads and %0d queries (%0d empty windows), %0d results",
             n_loads, n_queries, n_empty, n_results);
    $display("strides 0..31 and pads 0..15 across eight settings, with stalls on both sides");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/mp3d_pkg.sv
src/mp3d_front.sv
src/mp3d_back.sv
src/max_pool_3d_with_argmax_core.sv
tb/tb_max_pool_3d_with_argmax_core.sv
